/* sv/dvrt_pkg.sv */
// Shared types, codes and constants of the distance-vector route table.
package dvrt_pkg;

    localparam int NODE_W            = 4;
    localparam int NODE_SPACE        = 2 ** NODE_W;
    localparam int FIELD_COST_W      = 8;
    localparam int DEF_MAX_NODES     = 16;
    localparam int DEF_COST_INFINITY = 255;

    typedef enum logic [2:0] {
        OP_VECTOR    = 3'd0,
        OP_DATA      = 3'd1,
        OP_ADD       = 3'd2,
        OP_REMOVE    = 3'd3,
        OP_ADVERTISE = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        ST_DONE      = 3'd0,
        ST_FORWARD   = 3'd1,
        ST_DELIVERED = 3'd2,
        ST_NO_ROUTE  = 3'd3,
        ST_REJECTED  = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_VEC_TGT,
        S_VEC_UPD,
        S_DATA,
        S_RM_RD,
        S_RM_WR,
        S_RM_END,
        S_ADV_RD,
        S_ADV,
        S_ADV_END
    } state_t;

    typedef struct packed {
        logic [2:0]              operation;
        logic [NODE_W-1:0]       peer_node;
        logic [NODE_W-1:0]       target_node;
        logic [FIELD_COST_W-1:0] entry_cost;
        logic                    last_entry;
    } req_t;

    typedef struct packed {
        status_t                 status;
        logic [NODE_W-1:0]       forward_hop;
        logic                    table_changed;
        logic                    adv_valid;
        logic [NODE_W-1:0]       adv_dest;
        logic [FIELD_COST_W-1:0] adv_cost;
        logic                    last_result;
    } rsp_t;

endpackage

/* sv/dvrt_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
module dvrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* sv/distance_vector_route_table.sv */
// Top level of the distance-vector route table: sequencer, valid bits and result register.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+------------------------------
//   request | in        | req_valid / req_ready | req (req_t)
//   result  | out       | rsp_valid / rsp_ready | rsp (rsp_t)
//   config  | in        | cfg_we                | cfg_wdata (own node)
//
// Remove and advertise walk all N = min(MAX_NODES, 16) table entries, each read before
// it is acted on; one RAM read port paces every walk.
// A new word is taken only once the sequencer is back in idle.
// Reset clears the route valid bits and the neighbor set at once; cost/hop RAM is not cleared.
// A full result register holds the sequencer wherever it has a word to hand over.
module distance_vector_route_table
    import dvrt_pkg::*;
#(
    parameter int MAX_NODES     = DEF_MAX_NODES,
    parameter int COST_INFINITY = DEF_COST_INFINITY
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  req_t              req,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output rsp_t              rsp,
    input  logic              cfg_we,
    input  logic [NODE_W-1:0] cfg_wdata
);

    localparam int TABLE_SIZE = (MAX_NODES < NODE_SPACE) ? MAX_NODES : NODE_SPACE;
    localparam int IDX_W      = $clog2(TABLE_SIZE);
    localparam int COST_W     = $clog2(COST_INFINITY + 1);
    localparam int SUM_W      = COST_W + FIELD_COST_W;
    localparam int RAM_W      = NODE_W + COST_W;

    localparam logic [COST_W-1:0] INF      = COST_W'(COST_INFINITY);
    localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(TABLE_SIZE - 1);

    state_t                  state_reg, state_next;
    req_t                    item_reg, item_next;
    logic [NODE_W-1:0]       own_node_reg;
    logic [TABLE_SIZE-1:0]   route_present_reg, route_present_next;
    logic [TABLE_SIZE-1:0]   neighbor_present_reg, neighbor_present_next;
    logic                    packet_changed_reg, packet_changed_next;
    logic [COST_W-1:0]       peer_cost_reg, peer_cost_next;
    logic [IDX_W-1:0]        cnt_reg, cnt_next;
    logic                    rm_changed_reg, rm_changed_next;
    logic                    pend_valid_reg, pend_valid_next;
    logic [NODE_W-1:0]       pend_dest_reg, pend_dest_next;
    logic [COST_W-1:0]       pend_cost_reg, pend_cost_next;
    logic                    rsp_valid_reg, rsp_valid_next;
    rsp_t                    rsp_reg, rsp_next;

    logic                    ram_we;
    logic [IDX_W-1:0]        ram_waddr;
    logic [RAM_W-1:0]        ram_wdata;
    logic [IDX_W-1:0]        ram_raddr;
    logic [RAM_W-1:0]        ram_rdata;
    logic [COST_W-1:0]       rd_cost;
    logic [NODE_W-1:0]       rd_hop;

    logic                    slot_free;
    logic                    peer_in;
    logic                    tgt_in;
    logic [IDX_W-1:0]        peer_idx;
    logic [IDX_W-1:0]        tgt_idx;
    logic [COST_W-1:0]       cost_c;
    logic                    tgt_present;
    logic [COST_W-1:0]       tgt_cost;
    logic [SUM_W-1:0]        sum_full;
    logic [COST_W-1:0]       sum_sat;
    logic                    replace;
    logic                    present_after;
    logic [NODE_W-1:0]       hop_after;
    logic                    poison;
    logic                    vec_chg;
    logic [COST_W-1:0]       vec_cost;
    logic                    adv_qual;
    logic                    emit;
    rsp_t                    emit_word;

    dvrt_ram #(
        .WIDTH (RAM_W),
        .DEPTH (TABLE_SIZE)
    ) u_route_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_cost  = ram_rdata[COST_W-1:0];
    assign rd_hop   = ram_rdata[COST_W +: NODE_W];

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign slot_free = !rsp_valid_reg || rsp_ready;

    assign peer_in  = {1'b0, item_reg.peer_node} < (NODE_W + 1)'(TABLE_SIZE);
    assign tgt_in   = {1'b0, item_reg.target_node} < (NODE_W + 1)'(TABLE_SIZE);
    assign peer_idx = item_reg.peer_node[IDX_W-1:0];
    assign tgt_idx  = item_reg.target_node[IDX_W-1:0];

    // clamp an advertised cost above infinity
    assign cost_c = (SUM_W'(item_reg.entry_cost) > SUM_W'(INF)) ?
                    INF : COST_W'(item_reg.entry_cost);

    // relaxation through the sender, then poisoning when the sender is the next hop
    assign tgt_present   = tgt_in && route_present_reg[tgt_idx];
    assign tgt_cost      = tgt_present ? rd_cost : INF;
    assign sum_full      = SUM_W'(cost_c) + SUM_W'(peer_cost_reg);
    assign sum_sat       = (sum_full > SUM_W'(INF)) ? INF : COST_W'(sum_full);
    assign replace       = sum_sat < tgt_cost;
    assign present_after = tgt_present || replace;
    assign hop_after     = replace ? item_reg.peer_node : rd_hop;
    assign poison        = (cost_c == INF) && present_after && (hop_after == item_reg.peer_node);
    assign vec_chg       = replace || poison;
    assign vec_cost      = poison ? INF : sum_sat;

    // split horizon: skip routes through the target and the route to the target
    assign adv_qual = route_present_reg[cnt_reg] && (rd_hop != item_reg.peer_node) &&
                      (NODE_W'(cnt_reg) != item_reg.peer_node);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg            <= S_IDLE;
            own_node_reg         <= '0;
            route_present_reg    <= '0;
            neighbor_present_reg <= '0;
            packet_changed_reg   <= 1'b0;
            cnt_reg              <= '0;
            rm_changed_reg       <= 1'b0;
            pend_valid_reg       <= 1'b0;
            rsp_valid_reg        <= 1'b0;
        end
        else
        begin
            state_reg            <= state_next;
            route_present_reg    <= route_present_next;
            neighbor_present_reg <= neighbor_present_next;
            packet_changed_reg   <= packet_changed_next;
            cnt_reg              <= cnt_next;
            rm_changed_reg       <= rm_changed_next;
            pend_valid_reg       <= pend_valid_next;
            rsp_valid_reg        <= rsp_valid_next;
            if (cfg_we)
            begin
                own_node_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg      <= item_next;
        peer_cost_reg <= peer_cost_next;
        pend_dest_reg <= pend_dest_next;
        pend_cost_reg <= pend_cost_next;
        rsp_reg       <= rsp_next;
    end

    always_comb
    begin
        state_next            = state_reg;
        item_next             = item_reg;
        route_present_next    = route_present_reg;
        neighbor_present_next = neighbor_present_reg;
        packet_changed_next   = packet_changed_reg;
        peer_cost_next        = peer_cost_reg;
        cnt_next              = cnt_reg;
        rm_changed_next       = rm_changed_reg;
        pend_valid_next       = pend_valid_reg;
        pend_dest_next        = pend_dest_reg;
        pend_cost_next        = pend_cost_reg;
        rsp_valid_next        = rsp_valid_reg && !rsp_ready;
        rsp_next              = rsp_reg;

        ram_we    = 1'b0;
        ram_waddr = tgt_idx;
        ram_wdata = {item_reg.peer_node, vec_cost};
        ram_raddr = tgt_idx;

        emit                    = 1'b0;
        emit_word               = '0;
        emit_word.status        = ST_DONE;
        emit_word.last_result   = 1'b1;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    item_next  = req;
                    state_next = S_DECODE;
                end
            end

            S_DECODE:
            begin
                ram_raddr = (item_reg.operation == OP_VECTOR) ? peer_idx : tgt_idx;
                unique case (item_reg.operation)
                    OP_VECTOR:
                    begin
                        if (tgt_in)
                        begin
                            state_next = S_VEC_TGT;
                        end
                        else if (slot_free)
                        begin
                            emit                    = 1'b1;
                            emit_word.table_changed = item_reg.last_entry && packet_changed_reg;
                            if (item_reg.last_entry)
                            begin
                                packet_changed_next = 1'b0;
                            end
                            state_next = S_IDLE;
                        end
                    end

                    OP_DATA:
                    begin
                        if (item_reg.target_node == own_node_reg)
                        begin
                            if (slot_free)
                            begin
                                emit             = 1'b1;
                                emit_word.status = ST_DELIVERED;
                                state_next       = S_IDLE;
                            end
                        end
                        else if (tgt_present)
                        begin
                            state_next = S_DATA;
                        end
                        else if (slot_free)
                        begin
                            emit             = 1'b1;
                            emit_word.status = ST_NO_ROUTE;
                            state_next       = S_IDLE;
                        end
                    end

                    OP_ADD:
                    begin
                        if (slot_free)
                        begin
                            emit       = 1'b1;
                            state_next = S_IDLE;
                            if (!peer_in || neighbor_present_reg[peer_idx])
                            begin
                                emit_word.status = ST_REJECTED;
                            end
                            else
                            begin
                                neighbor_present_next[peer_idx] = 1'b1;
                                route_present_next[peer_idx]    = 1'b1;
                                ram_we    = 1'b1;
                                ram_waddr = peer_idx;
                                ram_wdata = {item_reg.peer_node, cost_c};
                            end
                        end
                    end

                    OP_REMOVE:
                    begin
                        if (!peer_in || !neighbor_present_reg[peer_idx])
                        begin
                            if (slot_free)
                            begin
                                emit             = 1'b1;
                                emit_word.status = ST_REJECTED;
                                state_next       = S_IDLE;
                            end
                        end
                        else
                        begin
                            neighbor_present_next[peer_idx] = 1'b0;
                            cnt_next        = '0;
                            rm_changed_next = 1'b0;
                            state_next      = S_RM_RD;
                        end
                    end

                    OP_ADVERTISE:
                    begin
                        cnt_next        = '0;
                        pend_valid_next = 1'b0;
                        state_next      = S_ADV_RD;
                    end

                    default:
                    begin
                        if (slot_free)
                        begin
                            emit             = 1'b1;
                            emit_word.status = ST_REJECTED;
                            state_next       = S_IDLE;
                        end
                    end
                endcase
            end

            S_VEC_TGT:
            begin
                // read data holds the sender's entry
                peer_cost_next = (peer_in && route_present_reg[peer_idx]) ? rd_cost : INF;
                state_next     = S_VEC_UPD;
            end

            S_VEC_UPD:
            begin
                if (slot_free)
                begin
                    if (vec_chg)
                    begin
                        ram_we                      = 1'b1;
                        route_present_next[tgt_idx] = 1'b1;
                    end
                    emit                    = 1'b1;
                    emit_word.table_changed = item_reg.last_entry &&
                                              (packet_changed_reg || vec_chg);
                    packet_changed_next     = !item_reg.last_entry &&
                                              (packet_changed_reg || vec_chg);
                    state_next              = S_IDLE;
                end
            end

            S_DATA:
            begin
                if (slot_free)
                begin
                    emit       = 1'b1;
                    state_next = S_IDLE;
                    if (rd_cost < INF)
                    begin
                        emit_word.status      = ST_FORWARD;
                        emit_word.forward_hop = rd_hop;
                    end
                    else
                    begin
                        emit_word.status = ST_NO_ROUTE;
                    end
                end
            end

            S_RM_RD:
            begin
                ram_raddr  = cnt_reg;
                state_next = S_RM_WR;
            end

            S_RM_WR:
            begin
                ram_raddr = cnt_reg;
                if (route_present_reg[cnt_reg] && (rd_hop == item_reg.peer_node))
                begin
                    ram_we          = 1'b1;
                    ram_waddr       = cnt_reg;
                    ram_wdata       = {rd_hop, INF};
                    rm_changed_next = 1'b1;
                end
                if (cnt_reg == LAST_IDX)
                begin
                    state_next = S_RM_END;
                end
                else
                begin
                    cnt_next   = cnt_reg + IDX_W'(1);
                    state_next = S_RM_RD;
                end
            end

            S_RM_END:
            begin
                if (slot_free)
                begin
                    emit                    = 1'b1;
                    emit_word.table_changed = rm_changed_reg;
                    state_next              = S_IDLE;
                end
            end

            S_ADV_RD:
            begin
                ram_raddr  = cnt_reg;
                state_next = S_ADV;
            end

            S_ADV:
            begin
                ram_raddr = cnt_reg;
                // hold the pair found last until the next one shows it is not final
                if (!(adv_qual && pend_valid_reg && !slot_free))
                begin
                    if (adv_qual)
                    begin
                        if (pend_valid_reg)
                        begin
                            emit                  = 1'b1;
                            emit_word.adv_valid   = 1'b1;
                            emit_word.adv_dest    = pend_dest_reg;
                            emit_word.adv_cost    = FIELD_COST_W'(pend_cost_reg);
                            emit_word.last_result = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_dest_next  = NODE_W'(cnt_reg);
                        pend_cost_next  = rd_cost;
                    end
                    if (cnt_reg == LAST_IDX)
                    begin
                        state_next = S_ADV_END;
                    end
                    else
                    begin
                        cnt_next   = cnt_reg + IDX_W'(1);
                        state_next = S_ADV_RD;
                    end
                end
            end

            S_ADV_END:
            begin
                if (slot_free)
                begin
                    emit = 1'b1;
                    if (pend_valid_reg)
                    begin
                        emit_word.adv_valid = 1'b1;
                        emit_word.adv_dest  = pend_dest_reg;
                        emit_word.adv_cost  = FIELD_COST_W'(pend_cost_reg);
                    end
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (emit)
        begin
            rsp_next       = emit_word;
            rsp_valid_next = 1'b1;
        end
    end

    // routes are never dropped from the table, only poisoned
    a_route_kept: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> ((route_present_reg & $past(route_present_reg)) == $past(route_present_reg)))
        else $error("route valid bit cleared");

    // a neighbor leaves the set only through a removal
    a_neighbor_removal: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> ((($past(neighbor_present_reg) & ~neighbor_present_reg) == '0) ||
                  $past((state_reg == S_DECODE) && (item_reg.operation == OP_REMOVE))))
        else $error("neighbor dropped outside a removal");

    // a word that is not the final one leaves the sequencer busy
    a_more_results: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_ready && !rsp.last_result) |-> (state_reg != S_IDLE))
        else $error("sequencer idle with results still owed");

    // no advertisement pair is held across items
    a_no_stale_pair: assert property (@(posedge clk) disable iff (!rst_n)
        req_ready |-> !pend_valid_reg)
        else $error("pending pair left at idle");

endmodule

/* tb/dvrt_table_check.sv */
// Route table predictor and result comparison for the distance-vector route table.
`timescale 1ns / 100ps

module dvrt_table_check
    import dvrt_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    input  logic              req_ready,
    input  req_t              req,
    input  logic              rsp_valid,
    input  logic              rsp_ready,
    input  rsp_t              rsp,
    input  logic              cfg_we,
    input  logic [NODE_W-1:0] cfg_wdata,
    output int                mismatches,
    output int                outstanding
);

    localparam int TABLE_N = (DEF_MAX_NODES < NODE_SPACE) ? DEF_MAX_NODES : NODE_SPACE;
    localparam int INF     = DEF_COST_INFINITY;

    logic [NODE_SPACE-1:0] rt_present;
    logic [NODE_SPACE-1:0] nbr_set;
    int                    rt_cost [NODE_SPACE];
    logic [NODE_W-1:0]     rt_hop [NODE_SPACE];
    logic [NODE_W-1:0]     own_id;
    logic                  vector_dirty;
    rsp_t                  route_outcomes [$];

    function automatic int cost_to_node(input int n);
        if (n < TABLE_N && rt_present[n])
            return rt_cost[n];
        return INF;
    endfunction

    function automatic rsp_t outcome(input status_t st, input logic [NODE_W-1:0] hop,
                                     input logic changed, input logic av,
                                     input logic [NODE_W-1:0] ad,
                                     input logic [FIELD_COST_W-1:0] ac, input logic last);
        rsp_t r;
        r.status        = st;
        r.forward_hop   = hop;
        r.table_changed = changed;
        r.adv_valid     = av;
        r.adv_dest      = ad;
        r.adv_cost      = ac;
        r.last_result   = last;
        return r;
    endfunction

    // append one expected result word
    function automatic void note_outcome(input rsp_t r);
        route_outcomes = {route_outcomes, r};
    endfunction

    task automatic predict_word(input req_t w);
        int   peer;
        int   tgt;
        int   cost;
        int   sum;
        int   last_i;
        logic changed;
        peer = int'(w.peer_node);
        tgt  = int'(w.target_node);
        cost = int'(w.entry_cost);
        if (cost > INF)
            cost = INF;
        case (op_t'(w.operation))
            OP_VECTOR:
            begin
                if (tgt < TABLE_N)
                begin
                    sum = cost + cost_to_node(peer);
                    if (sum > INF)
                        sum = INF;
                    if (sum < cost_to_node(tgt))
                    begin
                        rt_present[tgt] = 1'b1;
                        rt_cost[tgt]    = sum;
                        rt_hop[tgt]     = w.peer_node;
                        vector_dirty    = 1'b1;
                    end
                    // poison when the sender withdraws the route it carries
                    if (cost == INF && rt_present[tgt] && rt_hop[tgt] == peer)
                    begin
                        rt_cost[tgt] = INF;
                        vector_dirty = 1'b1;
                    end
                end
                if (w.last_entry)
                begin
                    note_outcome(outcome(ST_DONE, '0, vector_dirty, 1'b0, '0, '0, 1'b1));
                    vector_dirty = 1'b0;
                end
                else
                    note_outcome(outcome(ST_DONE, '0, 1'b0, 1'b0, '0, '0, 1'b1));
            end
            OP_DATA:
            begin
                if (w.target_node == own_id)
                    note_outcome(outcome(ST_DELIVERED, '0, 1'b0, 1'b0, '0, '0, 1'b1));
                else if (tgt < TABLE_N && rt_present[tgt] && rt_cost[tgt] < INF)
                    note_outcome(outcome(ST_FORWARD, rt_hop[tgt], 1'b0, 1'b0, '0, '0, 1'b1));
                else
                    note_outcome(outcome(ST_NO_ROUTE, '0, 1'b0, 1'b0, '0, '0, 1'b1));
            end
            OP_ADD:
            begin
                if (peer >= TABLE_N || nbr_set[peer])
                    note_outcome(outcome(ST_REJECTED, '0, 1'b0, 1'b0, '0, '0, 1'b1));
                else
                begin
                    nbr_set[peer]    = 1'b1;
                    rt_present[peer] = 1'b1;
                    rt_cost[peer]    = cost;
                    rt_hop[peer]     = w.peer_node;
                    note_outcome(outcome(ST_DONE, '0, 1'b0, 1'b0, '0, '0, 1'b1));
                end
            end
            OP_REMOVE:
            begin
                if (peer >= TABLE_N || !nbr_set[peer])
                    note_outcome(outcome(ST_REJECTED, '0, 1'b0, 1'b0, '0, '0, 1'b1));
                else
                begin
                    changed       = 1'b0;
                    nbr_set[peer] = 1'b0;
                    for (int i = 0; i < TABLE_N; i++)
                    begin
                        if (rt_present[i] && rt_hop[i] == peer)
                        begin
                            rt_cost[i] = INF;
                            changed    = 1'b1;
                        end
                    end
                    note_outcome(outcome(ST_DONE, '0, changed, 1'b0, '0, '0, 1'b1));
                end
            end
            OP_ADVERTISE:
            begin
                // split horizon: skip routes through the target and the target itself
                last_i = -1;
                for (int i = 0; i < TABLE_N; i++)
                    if (rt_present[i] && rt_hop[i] != peer && i != peer)
                        last_i = i;
                if (last_i < 0)
                    note_outcome(outcome(ST_DONE, '0, 1'b0, 1'b0, '0, '0, 1'b1));
                else
                    for (int i = 0; i < TABLE_N; i++)
                        if (rt_present[i] && rt_hop[i] != peer && i != peer)
                            note_outcome(outcome(ST_DONE, '0, 1'b0, 1'b1, NODE_W'(i),
                                                 rt_cost[i][FIELD_COST_W-1:0],
                                                 i == last_i));
            end
            default:
                note_outcome(outcome(ST_REJECTED, '0, 1'b0, 1'b0, '0, '0, 1'b1));
        endcase
    endtask

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        if (!rst_n)
        begin
            rt_present   = '0;
            nbr_set      = '0;
            own_id       = '0;
            vector_dirty = 1'b0;
            mismatches   = 0;
            route_outcomes.delete();
            outstanding <= 0;
        end
        else
        begin
            // compare first so a word accepted at this edge never matches an older result
            if (rsp_valid && rsp_ready)
            begin
                if (route_outcomes.size() == 0)
                begin
                    $error("result word with nothing expected: %h", rsp);
                    mismatches++;
                end
                else
                begin
                    want = route_outcomes.pop_front();
                    check_field("status", 8'(want.status), 8'(rsp.status));
                    check_field("forward_hop", 8'(want.forward_hop), 8'(rsp.forward_hop));
                    check_field("table_changed", 8'(want.table_changed),
                                8'(rsp.table_changed));
                    check_field("adv_valid", 8'(want.adv_valid), 8'(rsp.adv_valid));
                    check_field("adv_dest", 8'(want.adv_dest), 8'(rsp.adv_dest));
                    check_field("adv_cost", want.adv_cost, rsp.adv_cost);
                    check_field("last_result", 8'(want.last_result), 8'(rsp.last_result));
                end
            end
            if (cfg_we)
                own_id = cfg_wdata;
            if (req_valid && req_ready)
                predict_word(req);
            outstanding <= route_outcomes.size();
        end
    end

endmodule

/* tb/tb_distance_vector_route_table.sv */
// Stimulus and verdict for the distance-vector route table.
`timescale 1ns / 100ps

module tb_distance_vector_route_table;
    import dvrt_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 60;
    localparam int PHASE_WORDS    = 100;
    localparam logic [2:0] OP_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] OP_UNUSED_LAST  = 3'd7;
    localparam logic [FIELD_COST_W-1:0] COST_INF = FIELD_COST_W'(DEF_COST_INFINITY);

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              req_valid = 1'b0;
    logic              req_ready;
    req_t              req       = '0;
    logic              rsp_valid;
    logic              rsp_ready = 1'b0;
    rsp_t              rsp;
    logic              cfg_we    = 1'b0;
    logic [NODE_W-1:0] cfg_wdata = '0;

    int                    fail_count;
    int                    outstanding;
    int                    idle_cycles = 0;
    int                    stall_left  = 0;
    int                    sent_words  = 0;
    bit                    no_gaps     = 1'b0;
    logic [NODE_SPACE-1:0] nbr_mask    = '0;
    logic [NODE_W-1:0]     own_cfg     = '0;

    distance_vector_route_table dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    dvrt_table_check u_table_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req         (req),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .rsp         (rsp),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .mismatches  (fail_count),
        .outstanding (outstanding)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // result side: short stalls mostly, a few long ones, and long open stretches
    always @(posedge clk)
    begin
        int r;
        if (!rst_n)
            rsp_ready <= 1'b0;
        else if (stall_left != 0)
            stall_left <= stall_left - 1;
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 60)
            begin
                rsp_ready  <= 1'b1;
                stall_left <= $urandom_range(0, 7);
            end
            else if (r < 70)
            begin
                rsp_ready  <= 1'b1;
                stall_left <= $urandom_range(30, 80);
            end
            else if (r < 95)
            begin
                rsp_ready  <= 1'b0;
                stall_left <= $urandom_range(0, 3);
            end
            else
            begin
                rsp_ready  <= 1'b0;
                stall_left <= $urandom_range(10, 40);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    function automatic req_t route_word(input logic [2:0] op, input logic [NODE_W-1:0] peer,
                                        input logic [NODE_W-1:0] tgt,
                                        input logic [FIELD_COST_W-1:0] cost, input logic last);
        req_t w;
        w.operation   = op;
        w.peer_node   = peer;
        w.target_node = tgt;
        w.entry_cost  = cost;
        w.last_entry  = last;
        return w;
    endfunction

    function automatic int pick_gap();
        int r;
        if (no_gaps)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [NODE_W-1:0] any_node();
        return NODE_W'($urandom_range(0, NODE_SPACE - 1));
    endfunction

    function automatic logic [NODE_W-1:0] pick_neighbor();
        logic [NODE_W-1:0] n;
        n = any_node();
        if (nbr_mask != '0 && $urandom_range(0, 9) < 8)
            while (!nbr_mask[n])
                n = any_node();
        return n;
    endfunction

    function automatic logic [NODE_W-1:0] pick_stranger();
        logic [NODE_W-1:0] n;
        n = any_node();
        if (nbr_mask != '1)
            while (nbr_mask[n])
                n = any_node();
        return n;
    endfunction

    function automatic logic [FIELD_COST_W-1:0] pick_cost();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return FIELD_COST_W'($urandom_range(0, 15));
        if (r < 75)
            return COST_INF;
        if (r < 95)
            return FIELD_COST_W'($urandom_range(16, 254));
        return FIELD_COST_W'($urandom_range(0, 255));
    endfunction

    task automatic send_word(input req_t w);
        int gap;
        gap = pick_gap();
        if (gap != 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req       <= w;
        req_valid <= 1'b1;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        sent_words++;
        if (w.operation == OP_ADD)
            nbr_mask[w.peer_node] = 1'b1;
        else if (w.operation == OP_REMOVE)
            nbr_mask[w.peer_node] = 1'b0;
    endtask

    task automatic wait_drained();
        req_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    task automatic write_own_node(input logic [NODE_W-1:0] id);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= id;
        own_cfg    = id;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic run_random_phase(input int count);
        int                start;
        int                r;
        int                n;
        bit                broken;
        logic [NODE_W-1:0] sender;
        logic [NODE_W-1:0] tgt;
        start = sent_words;
        while (sent_words - start < count)
        begin
            if ($urandom_range(0, 29) == 0)
                no_gaps = !no_gaps;
            r = $urandom_range(0, 99);
            if (r < 40)
            begin
                // one received vector packet; a few lose their last flag or mix senders
                n      = $urandom_range(1, 5);
                sender = pick_neighbor();
                broken = ($urandom_range(0, 9) == 0);
                for (int k = 0; k < n; k++)
                begin
                    if (broken && $urandom_range(0, 1) == 1)
                        sender = any_node();
                    send_word(route_word(OP_VECTOR, sender, any_node(), pick_cost(),
                                         (k == n - 1) && !broken));
                end
            end
            else if (r < 60)
            begin
                tgt = ($urandom_range(0, 4) == 0) ? own_cfg : any_node();
                send_word(route_word(OP_DATA, any_node(), tgt, FIELD_COST_W'($urandom),
                                     1'($urandom)));
            end
            else if (r < 72)
                send_word(route_word(OP_ADD,
                                     ($urandom_range(0, 9) < 7) ? pick_stranger() : any_node(),
                                     any_node(), pick_cost(), 1'($urandom)));
            else if (r < 80)
                send_word(route_word(OP_REMOVE, pick_neighbor(), any_node(),
                                     FIELD_COST_W'($urandom), 1'($urandom)));
            else if (r < 95)
                send_word(route_word(OP_ADVERTISE, pick_neighbor(), any_node(),
                                     FIELD_COST_W'($urandom), 1'($urandom)));
            else if (r < 97)
                send_word(route_word(3'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST)),
                                     any_node(), any_node(), FIELD_COST_W'($urandom),
                                     1'($urandom)));
            else
                wait_drained();
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        write_own_node(4'd4);
        send_word(route_word(OP_DATA, 4'd0, 4'd4, 8'd0, 1'b0));
        send_word(route_word(OP_DATA, 4'd0, 4'd0, 8'd0, 1'b0));
        send_word(route_word(OP_ADVERTISE, 4'd0, 4'd0, 8'd0, 1'b0));
        send_word(route_word(OP_REMOVE, 4'd3, 4'd0, 8'd0, 1'b0));
        send_word(route_word(OP_ADD, 4'd1, 4'd0, 8'd1, 1'b0));
        send_word(route_word(OP_ADD, 4'd1, 4'd0, 8'd9, 1'b0));
        send_word(route_word(OP_ADD, 4'd15, 4'd15, COST_INF, 1'b1));
        send_word(route_word(OP_ADD, 4'd0, 4'd0, 8'd0, 1'b0));
        send_word(route_word(OP_VECTOR, 4'd1, 4'd3, 8'd2, 1'b0));
        send_word(route_word(OP_VECTOR, 4'd1, 4'd3, 8'd254, 1'b1));
        send_word(route_word(OP_DATA, 4'd0, 4'd3, 8'd0, 1'b0));
        // sender at infinity and sender with no route: neither improves anything
        send_word(route_word(OP_VECTOR, 4'd15, 4'd7, 8'd0, 1'b1));
        send_word(route_word(OP_VECTOR, 4'd9, 4'd8, 8'd0, 1'b1));
        send_word(route_word(OP_VECTOR, 4'd0, 4'd3, 8'd0, 1'b0));
        send_word(route_word(OP_VECTOR, 4'd0, 4'd3, COST_INF, 1'b1));
        send_word(route_word(OP_DATA, 4'd0, 4'd3, 8'd0, 1'b0));
        send_word(route_word(OP_DATA, 4'd0, 4'd15, 8'd0, 1'b0));
        send_word(route_word(OP_VECTOR, 4'd1, 4'd12, 8'd7, 1'b1));
        send_word(route_word(OP_ADVERTISE, 4'd1, 4'd0, 8'd0, 1'b0));
        send_word(route_word(OP_ADVERTISE, 4'd9, 4'd0, 8'd0, 1'b0));
        send_word(route_word(OP_REMOVE, 4'd1, 4'd0, 8'd0, 1'b0));
        send_word(route_word(OP_REMOVE, 4'd1, 4'd0, 8'd0, 1'b0));
        for (int op = OP_UNUSED_FIRST; op <= OP_UNUSED_LAST; op++)
            send_word(route_word(3'(op), 4'd15, 4'd15, 8'hff, 1'b1));
        send_word(route_word(OP_REMOVE, 4'd15, 4'd0, 8'd0, 1'b0));

        write_own_node(4'd15);
        run_random_phase(PHASE_WORDS);
        write_own_node(4'd0);
        run_random_phase(PHASE_WORDS);
        write_own_node(any_node());
        run_random_phase(PHASE_WORDS);
        write_own_node(any_node());
        run_random_phase(PHASE_WORDS);

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
